// File: rtl/bclru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank cache package
// Shared widths, codes and the structs that pass between the top level and
// the slot cells.
// ----------------------------------------------------------------------------
package bclru_pkg;

   localparam int BANK_W  = 9;
   localparam int STAMP_W = 16;
   localparam int IDX_W   = 6;
   localparam int NUM_WIN = 4;
   localparam int WIN_W   = 2;
   localparam int CNT_W   = 5;

   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   localparam logic CSR_STREAMED_MODE = 1'b0;
   localparam logic CSR_SLOT_COUNT    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   // search token walking down the cell row
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [IDX_W-1:0]   hit_idx;
      logic [STAMP_W-1:0] best;
      logic [IDX_W-1:0]   victim;
   } probe_type;

   // request bank and banks held by the other windows
   typedef struct packed {
      logic [BANK_W-1:0]              bank;
      logic [NUM_WIN-1:0]             guard_en;
      logic [NUM_WIN-1:0][BANK_W-1:0] guard_bank;
   } lookup_type;

   // stamp or refill of one slot
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic               set_tag;
      logic [BANK_W-1:0]  tag;
      logic [STAMP_W-1:0] stamp;
   } update_type;

endpackage

// File: rtl/bclru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank cache slot cell
// Holds one slot's tag and use stamp, folds them into the passing search
// token and registers the token for the next cell.
// ----------------------------------------------------------------------------
module bclru_cell #(
   parameter int SLOT_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  slot_en,
   input  bclru_pkg::lookup_type lookup,
   input  bclru_pkg::update_type update,
   input  bclru_pkg::probe_type  probe_i,
   output bclru_pkg::probe_type  probe_o
);
   import bclru_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_IDX);

   logic               valid_ff;
   logic [BANK_W-1:0]  tag_ff;
   logic [STAMP_W-1:0] stamp_ff;
   probe_type          probe_ff;
   probe_type          probe_in;
   logic               match;
   logic               guarded;
   logic               sel;

   always_comb begin
      guarded = 1'b0;
      for (int k = 0; k < NUM_WIN; k++) begin
         if (lookup.guard_en[k] && (lookup.guard_bank[k] == tag_ff)) begin
            guarded = 1'b1;
         end
      end
      guarded = guarded && valid_ff;
      match   = valid_ff && (tag_ff == lookup.bank);
      sel     = update.en && (update.idx == MY_IDX);

      probe_in = probe_i;
      if (probe_i.valid && slot_en) begin
         // first match wins: lower slots are visited first
         if (match && !probe_i.hit) begin
            probe_in.hit     = 1'b1;
            probe_in.hit_idx = MY_IDX;
         end
         // later slots win ties
         if (!guarded && (stamp_ff <= probe_i.best)) begin
            probe_in.best   = stamp_ff;
            probe_in.victim = MY_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
         valid_ff       <= 1'b0;
         stamp_ff       <= '0;
      end else begin
         probe_ff.valid <= probe_in.valid;
         if (sel) begin
            stamp_ff <= update.stamp;
            if (update.set_tag) begin
               valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      probe_ff.hit     <= probe_in.hit;
      probe_ff.hit_idx <= probe_in.hit_idx;
      probe_ff.best    <= probe_in.best;
      probe_ff.victim  <= probe_in.victim;
      if (sel && update.set_tag) begin
         tag_ff <= update.tag;
      end
   end

   assign probe_o = probe_ff;

endmodule

// File: rtl/bank_cache_lru_with_window_protect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank cache with window protection
// Maps a request for an 8K bank in one of four program windows to a location:
// the bank itself when the whole image is resident, or a cache slot picked by
// least-recently-used replacement that spares banks other windows still map.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_window, req_bank
//   rsp      out        rsp_valid / rsp_ready  rsp_location, rsp_hit,
//                                              rsp_fill_request, rsp_fill_bank
//   csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// Resident mode: the response loads on the accepting edge.
// Streamed mode: the request is held on accept, then the launch register starts
// the search token into the row of MAX_SLOTS cells, which it walks one cell per
// cycle; the commit state then stamps/refills the slot and loads the response.
// One request is in flight at a time; a full response register stalls commit
// and holds off resident requests. Reset clears all slots, stamps and window
// mappings at once; no clearing pass.
// ----------------------------------------------------------------------------
module bank_cache_lru_with_window_protect #(
   parameter int MAX_SLOTS = 16,
   parameter int MAX_BANKS = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bclru_pkg::WIN_W-1:0]  req_window,
   input  logic [bclru_pkg::BANK_W-1:0] req_bank,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bclru_pkg::BANK_W-1:0] rsp_location,
   output logic                         rsp_hit,
   output logic                         rsp_fill_request,
   output logic [bclru_pkg::BANK_W-1:0] rsp_fill_bank,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [bclru_pkg::CNT_W-1:0]  csr_wdata
);
   import bclru_pkg::*;

   // banks wrap modulo MAX_BANKS (a power of two)
   localparam logic [BANK_W-1:0] BANK_MASK =
      (MAX_BANKS >= (1 << BANK_W)) ? '1 : BANK_W'(MAX_BANKS - 1);

   // configuration
   logic             mode_ff;
   logic [CNT_W-1:0] count_ff;

   // control and window state
   state_type                      state_ff, state_in;
   logic [STAMP_W-1:0]             clock_ff;
   logic [NUM_WIN-1:0]             win_valid_ff;
   logic [NUM_WIN-1:0][BANK_W-1:0] win_bank_ff;

   // held request and search result
   logic [WIN_W-1:0]  req_win_ff;
   logic [BANK_W-1:0] req_bank_ff;
   logic [BANK_W-1:0] bank_eff;
   probe_type         res_ff;
   logic              launch_ff;

   // response register
   logic              rsp_valid_ff;
   logic [BANK_W-1:0] rsp_location_ff;
   logic              rsp_hit_ff;
   logic              rsp_fill_ff;
   logic [BANK_W-1:0] rsp_fill_bank_ff;

   logic                 accept;
   logic                 commit;
   logic                 out_free;
   logic [IDX_W-1:0]     slot_idx;
   logic [MAX_SLOTS-1:0] slot_en;
   lookup_type           lookup;
   update_type           update;
   probe_type            probe [MAX_SLOTS+1];

   assign bank_eff = req_bank & BANK_MASK;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;
   assign slot_idx = res_ff.hit ? res_ff.hit_idx : res_ff.victim;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= CNT_W'(4);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STREAMED_MODE: mode_ff  <= csr_wdata[0];
            CSR_SLOT_COUNT:    count_ff <= csr_wdata;
            default:           mode_ff  <= mode_ff;
         endcase
      end
   end

   // sequencer: idle -> walk the cells -> commit
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // resident requests answer at once and need the response register
            req_ready = mode_ff || out_free;
            if (req_valid && req_ready && mode_ff) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (probe[MAX_SLOTS].valid) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // hold the result until the response register frees up
            if (out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // launch in the cycle after a streamed accept, once the request is held
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
      end else begin
         launch_ff <= accept && mode_ff;
      end
   end

   // fresh token into the first cell
   always_comb begin
      probe[0].valid   = launch_ff;
      probe[0].hit     = 1'b0;
      probe[0].hit_idx = '0;
      probe[0].best    = STAMP_MAX;
      probe[0].victim  = '0;
   end

   // broadcast: request bank and the banks other windows protect
   always_comb begin
      lookup.bank = req_bank_ff;
      for (int k = 0; k < NUM_WIN; k++) begin
         lookup.guard_en[k]   = win_valid_ff[k] && (WIN_W'(k) != req_win_ff);
         lookup.guard_bank[k] = win_bank_ff[k];
      end
   end

   // broadcast: stamp the hit slot, or refill and stamp the victim
   always_comb begin
      update.en      = commit;
      update.idx     = slot_idx;
      update.set_tag = !res_ff.hit;
      update.tag     = req_bank_ff;
      update.stamp   = clock_ff + STAMP_W'(1);
   end

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      assign slot_en[i] = (7'(count_ff) > 7'(i));

      bclru_cell #(
         .SLOT_IDX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .slot_en (slot_en[i]),
         .lookup  (lookup),
         .update  (update),
         .probe_i (probe[i]),
         .probe_o (probe[i+1])
      );
   end

   // hold request and search result
   always_ff @(posedge clock) begin
      if (accept) begin
         req_win_ff  <= req_window;
         req_bank_ff <= bank_eff;
      end
      if ((state_ff == ST_SEARCH) && probe[MAX_SLOTS].valid) begin
         res_ff <= probe[MAX_SLOTS];
      end
   end

   // use clock and window mappings advance on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff     <= '0;
         win_valid_ff <= '0;
      end else if (commit) begin
         clock_ff                 <= update.stamp;
         win_valid_ff[req_win_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         win_bank_ff[req_win_ff] <= req_bank_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((accept && !mode_ff) || commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !mode_ff) begin
         rsp_location_ff  <= bank_eff;
         rsp_hit_ff       <= 1'b1;
         rsp_fill_ff      <= 1'b0;
         rsp_fill_bank_ff <= '0;
      end else if (commit) begin
         rsp_location_ff  <= BANK_W'(slot_idx);
         rsp_hit_ff       <= res_ff.hit;
         rsp_fill_ff      <= !res_ff.hit;
         rsp_fill_bank_ff <= res_ff.hit ? '0 : req_bank_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_location     = rsp_location_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_fill_request = rsp_fill_ff;
   assign rsp_fill_bank    = rsp_fill_bank_ff;

   // checks
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request accepted while a search is in flight");

   a_token_only_in_search: assert property (@(posedge clock) disable iff (reset)
      probe[MAX_SLOTS].valid |-> (state_ff == ST_SEARCH))
      else $error("search token left the cell row outside a search");

   a_clock_tick: assert property (@(posedge clock) disable iff (reset)
      commit |=> (clock_ff == $past(clock_ff) + STAMP_W'(1)))
      else $error("use clock did not advance by one on commit");

   a_hit_xor_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hit_ff != rsp_fill_ff))
      else $error("response must be either a hit or a fill");

   a_commit_maps_window: assert property (@(posedge clock) disable iff (reset)
      commit |=> win_valid_ff[$past(req_win_ff)])
      else $error("window not mapped after commit");

endmodule
